// ===== rtl/stawa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stawa_pkg
// shared codes and entry layout for the source table with aging
// ----------------------------------------------------------------------------
package stawa_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_BEACON = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_PRUNE  = 2'd2;

    // status codes of a result word
    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_TICK      = 3'd3;
    localparam logic [2:0] ST_PRUNE     = 3'd4;

    localparam logic [31:0] MAX_AGE_RESET = 32'd60;

    // one table row as kept in the entry ram
    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] last_seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/stawa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stawa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module stawa_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/source_table_with_aging_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_table_with_aging_core
// learning table of beacon sources with a seconds counter and age pruning
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  ------------------------------------
//  in        input      i_in_valid / o_in_ready        i_operation, i_source_address,
//                                                      i_source_port
//  out       output     o_out_valid / i_out_ready      o_status, o_removed_count,
//                                                      o_entries_in_use
//  cfg       input      i_cfg_we (no wait)             i_cfg_wdata (maximum age)
//
//  a tick or an unused code passes from accept through S_DONE into the output register
//  a beacon or prune walks the entry ram one row per cycle through one compare /
//  age-subtract unit; a refresh ends at the match
//  the result sits in an output register; the next word is taken while it waits
//  reset (synchronous, active low) clears valid bits and counters, sets max age to MAX_AGE_RESET
//  entry payloads live in ram without reset and are only read behind a valid bit
// ----------------------------------------------------------------------------
module source_table_with_aging_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_source_port,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_removed_count,
    output logic [4:0]  o_entries_in_use,
    // maximum age register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(TABLE_ENTRIES);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]               r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]            r_count, n_count;
    logic [31:0]              r_seconds, n_seconds;
    logic [31:0]              r_max_age;
    logic [IW-1:0]            r_idx, n_idx;
    logic                     r_issued_all, n_issued_all;
    logic                     r_pend, n_pend;
    logic [IW-1:0]            r_pend_idx, n_pend_idx;
    logic                     r_free_found, n_free_found;
    logic [IW-1:0]            r_free_idx, n_free_idx;
    logic [CW-1:0]            r_removed, n_removed;
    logic [2:0]               r_res_status, n_res_status;
    logic                     r_o_valid, n_o_valid;

    // latched input word
    logic [1:0]               r_op, n_op;
    logic [31:0]              r_addr, n_addr;
    logic [15:0]              r_port, n_port;

    // output payload
    logic [2:0]               r_o_status, n_o_status;
    logic [4:0]               r_o_removed, n_o_removed;
    logic [4:0]               r_o_count, n_o_count;

    // entry ram access
    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    stawa_pkg::t_entry        ram_wentry;
    logic [stawa_pkg::ENTRY_W-1:0] ram_rdata;
    stawa_pkg::t_entry        rd_entry;

    // shared compare unit
    logic                     pend_valid;
    logic                     hit;
    logic [31:0]              age;
    logic                     expired;
    logic                     is_last;
    logic                     free_have;
    logic [IW-1:0]            free_slot;

    logic                     in_accept;
    logic                     out_free;
    logic [CW+4:0]            count_ext;
    logic [CW+4:0]            removed_ext;

    stawa_ram #(
        .WIDTH (stawa_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = stawa_pkg::t_entry'(ram_rdata);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;

    // compare / age unit on the row read last cycle
    assign pend_valid = r_valid[r_pend_idx];
    assign hit        = (rd_entry.address == r_addr) && (rd_entry.port == r_port);
    assign age        = r_seconds - rd_entry.last_seen;
    assign expired    = age > r_max_age;
    assign is_last    = (r_pend_idx == LAST_IDX);
    assign free_have  = r_free_found || !pend_valid;
    assign free_slot  = r_free_found ? r_free_idx : r_pend_idx;

    assign count_ext   = {5'd0, r_count};
    assign removed_ext = {5'd0, r_removed};

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_count      = r_count;
        n_seconds    = r_seconds;
        n_idx        = r_idx;
        n_issued_all = r_issued_all;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_removed    = r_removed;
        n_res_status = r_res_status;
        n_op         = r_op;
        n_addr       = r_addr;
        n_port       = r_port;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_removed  = r_o_removed;
        n_o_count    = r_o_count;

        ram_we             = 1'b0;
        ram_waddr          = r_pend_idx;
        ram_wentry.address = r_addr;
        ram_wentry.port    = r_port;
        ram_wentry.last_seen = r_seconds;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op         = i_operation;
                    n_addr       = i_source_address;
                    n_port       = i_source_port;
                    n_idx        = '0;
                    n_issued_all = 1'b0;
                    n_free_found = 1'b0;
                    n_removed    = '0;
                    case (i_operation)
                        stawa_pkg::OP_BEACON,
                        stawa_pkg::OP_PRUNE: begin
                            n_state = S_SCAN;
                        end
                        stawa_pkg::OP_TICK: begin
                            n_seconds    = r_seconds + 32'd1;
                            n_res_status = stawa_pkg::ST_TICK;
                            n_state      = S_DONE;
                        end
                        default: begin
                            // unused code: table and seconds stay as they are, result carries tick status
                            n_res_status = stawa_pkg::ST_TICK;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next row read
                if (!r_issued_all) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issued_all = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end

                // check the row that came back
                if (r_pend) begin
                    if (r_op == stawa_pkg::OP_BEACON) begin
                        if (pend_valid && hit) begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_pend_idx;
                            n_res_status = stawa_pkg::ST_REFRESHED;
                            n_state      = S_DONE;
                        end else begin
                            if (!r_free_found && !pend_valid) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_pend_idx;
                            end
                            if (is_last) begin
                                n_state = S_DONE;
                                if (free_have) begin
                                    ram_we             = 1'b1;
                                    ram_waddr          = free_slot;
                                    n_valid[free_slot] = 1'b1;
                                    n_count            = r_count + 1'b1;
                                    n_res_status       = stawa_pkg::ST_INSERTED;
                                end else begin
                                    n_res_status = stawa_pkg::ST_DROPPED;
                                end
                            end
                        end
                    end else begin
                        if (pend_valid && expired) begin
                            n_valid[r_pend_idx] = 1'b0;
                            n_count             = r_count - 1'b1;
                            n_removed           = r_removed + 1'b1;
                        end
                        if (is_last) begin
                            n_res_status = stawa_pkg::ST_PRUNE;
                            n_state      = S_DONE;
                        end
                    end
                end
            end

            S_DONE: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_removed = (r_res_status == stawa_pkg::ST_PRUNE) ? removed_ext[4:0]
                                                                        : 5'd0;
                    n_o_count   = count_ext[4:0];
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_count      <= '0;
            r_seconds    <= '0;
            r_max_age    <= stawa_pkg::MAX_AGE_RESET;
            r_idx        <= '0;
            r_issued_all <= 1'b0;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_removed    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_seconds    <= n_seconds;
            r_idx        <= n_idx;
            r_issued_all <= n_issued_all;
            r_pend       <= n_pend;
            r_free_found <= n_free_found;
            r_removed    <= n_removed;
            r_o_valid    <= n_o_valid;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_op         <= n_op;
        r_addr       <= n_addr;
        r_port       <= n_port;
        r_o_status   <= n_o_status;
        r_o_removed  <= n_o_removed;
        r_o_count    <= n_o_count;
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_removed_count  = r_o_removed;
    assign o_entries_in_use = r_o_count;

    // occupancy counter tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("entry count differs from valid bits");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("entry count beyond table size");

    // a tick word advances the seconds counter by one
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_operation == stawa_pkg::OP_TICK)
        |=> r_seconds == $past(r_seconds) + 32'd1)
        else $error("tick did not advance seconds");

    // only prune results carry a removal count
    a_removed_prune_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != stawa_pkg::ST_PRUNE) |-> o_removed_count == 5'd0)
        else $error("removal count on non-prune result");

    // the table is never written outside a scan
    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN) && r_pend)
        else $error("entry ram written outside scan");

endmodule
